// File: rtl/dts_pkg.sv
// Shared widths, codes and control structs for the deadline timer scheduler.
`default_nettype none

package dts_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam int OP_W     = 1;
  localparam int SLOT_ID_W = 4;
  localparam int DELAY_W  = 24;
  localparam int KIND_W   = 2;
  localparam int EV_W     = 2;
  localparam int TIME_W   = 32;

  // One RAM word per slot: {kind, period, deadline}.
  localparam int WORD_W = KIND_W + DELAY_W + TIME_W;

  localparam logic [OP_W-1:0] OP_ARM  = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_PERIODIC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NETWORK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ONESHOT  = 2'd2;

  localparam logic [EV_W-1:0] EV_ACK  = 2'd0;
  localparam logic [EV_W-1:0] EV_FIRE = 2'd1;
  localparam logic [EV_W-1:0] EV_DROP = 2'd2;

  typedef struct packed {
    logic latch;      // capture the accepted input word
    logic arm;        // write the slot if the request is valid and send the acknowledge
    logic tick;       // advance time and start the first scan pass
    logic scan;       // read the slot at the scan index and step it
    logic take_best;  // service the earliest due slot and start another pass
    logic finish;     // send the closing word of a tick
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic best_found;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/dts_in_if.sv
// Input channel of the scheduler: valid/ready handshake and request payload.
`default_nettype none

interface dts_in_if;
  logic                              valid;
  logic                              ready;
  logic [dts_pkg::OP_W-1:0]          operation;
  logic [dts_pkg::SLOT_ID_W-1:0]     slot_id;
  logic [dts_pkg::DELAY_W-1:0]       delay_ticks;
  logic [dts_pkg::KIND_W-1:0]        task_kind;

  modport source (output valid, operation, slot_id, delay_ticks, task_kind, input ready);
  modport sink   (input valid, operation, slot_id, delay_ticks, task_kind, output ready);
endinterface

`default_nettype wire

// File: rtl/dts_out_if.sv
// Output channel of the scheduler: valid/ready handshake and result payload.
`default_nettype none

interface dts_out_if;
  logic                              valid;
  logic                              ready;
  logic [dts_pkg::EV_W-1:0]          event_res;
  logic [dts_pkg::SLOT_ID_W-1:0]     fired_slot;
  logic [dts_pkg::KIND_W-1:0]        fired_kind;
  logic                              last_of_run;

  modport source (output valid, event_res, fired_slot, fired_kind, last_of_run, input ready);
  modport sink   (input valid, event_res, fired_slot, fired_kind, last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/dts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/dts_datapath.sv
// Datapath: time counter, slot table, earliest-deadline search and result registers.
`default_nettype none

module dts_datapath #(
  parameter int SLOT_COUNT = dts_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dts_pkg::cmd_t                 cmd,
  output      dts_pkg::stat_t                stat,
  input  wire logic [dts_pkg::SLOT_ID_W-1:0] slot_id,
  input  wire logic [dts_pkg::DELAY_W-1:0]   delay_ticks,
  input  wire logic [dts_pkg::KIND_W-1:0]    task_kind,
  output      logic                          rsp_valid,
  input  wire logic                          rsp_ready,
  output      logic [dts_pkg::EV_W-1:0]      event_res,
  output      logic [dts_pkg::SLOT_ID_W-1:0] fired_slot,
  output      logic [dts_pkg::KIND_W-1:0]    fired_kind,
  output      logic                          last_of_run
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CMP_W  = SLOT_W + dts_pkg::SLOT_ID_W + 1;
  localparam int TW     = dts_pkg::TIME_W;
  localparam int DW     = dts_pkg::DELAY_W;
  localparam int KW     = dts_pkg::KIND_W;

  // Latched request.
  logic [dts_pkg::SLOT_ID_W-1:0] lat_sid;
  logic [DW-1:0]                 lat_delay;
  logic [KW-1:0]                 lat_kind;

  logic [TW-1:0]         now_count;
  logic [SLOT_COUNT-1:0] armed;
  logic [SLOT_COUNT-1:0] done;
  logic [SLOT_W-1:0]     scan_idx;
  logic                  cmp_valid;
  logic [SLOT_W-1:0]     cmp_idx;

  logic                       best_found;
  logic [SLOT_W-1:0]          best_idx;
  logic [TW-1:0]              best_diff;
  logic [dts_pkg::WORD_W-1:0] best_word;

  logic                          pend_valid;
  logic [dts_pkg::EV_W-1:0]      pend_ev;
  logic [dts_pkg::SLOT_ID_W-1:0] pend_slot;
  logic [KW-1:0]                 pend_kind;

  logic                       ram_we;
  logic [SLOT_W-1:0]          ram_waddr;
  logic [dts_pkg::WORD_W-1:0] ram_wdata;
  logic [dts_pkg::WORD_W-1:0] ram_rdata;

  logic          arm_ok;
  logic [TW-1:0] cand_diff;
  logic          cand_due;
  logic          cand_take;
  logic [KW-1:0] best_kind;
  logic [DW-1:0] best_period;
  logic [TW-1:0] rearm_step;
  logic          out_free;
  logic          rsp_load;

  assign arm_ok = (CMP_W'(lat_sid) < CMP_W'(SLOT_COUNT)) && (lat_kind <= dts_pkg::KIND_ONESHOT);

  assign cand_diff = ram_rdata[TW-1:0] - now_count;
  assign cand_due  = cand_diff[TW-1] || (cand_diff == '0);
  // Strict less-than with an ascending scan hands ties to the lower slot.
  assign cand_take = cmp_valid && armed[cmp_idx] && !done[cmp_idx] && cand_due &&
                     (!best_found || ($signed(cand_diff) < $signed(best_diff)));

  assign best_kind   = best_word[dts_pkg::WORD_W-1 -: KW];
  assign best_period = best_word[TW +: DW];
  assign rearm_step  = (best_period == '0) ? TW'(1) : TW'(best_period);

  assign out_free = !rsp_valid || rsp_ready;
  assign rsp_load = cmd.arm || (cmd.take_best && pend_valid) || cmd.finish;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = SLOT_W'(lat_sid);
    ram_wdata = {lat_kind, lat_delay, now_count + TW'(lat_delay)};
    if (cmd.arm) begin
      ram_we = arm_ok;
    end else if (cmd.take_best) begin
      ram_we    = (best_kind == dts_pkg::KIND_PERIODIC);
      ram_waddr = best_idx;
      ram_wdata = {best_kind, best_period, now_count + rearm_step};
    end
  end

  dts_ram #(
    .WIDTH(dts_pkg::WORD_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.scan),
    .raddr(scan_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_sid   <= slot_id;
      lat_delay <= delay_ticks;
      lat_kind  <= task_kind;
    end
    cmp_idx <= scan_idx;
    if (cand_take) begin
      best_idx  <= cmp_idx;
      best_diff <= cand_diff;
      best_word <= ram_rdata;
    end
    if (cmd.take_best) begin
      pend_ev   <= (best_kind == dts_pkg::KIND_NETWORK) ? dts_pkg::EV_DROP : dts_pkg::EV_FIRE;
      pend_slot <= dts_pkg::SLOT_ID_W'(best_idx);
      pend_kind <= best_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_count   <= '0;
      armed       <= '0;
      done        <= '0;
      scan_idx    <= '0;
      cmp_valid   <= 1'b0;
      best_found  <= 1'b0;
      pend_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
      event_res   <= dts_pkg::EV_ACK;
      fired_slot  <= '0;
      fired_kind  <= dts_pkg::KIND_PERIODIC;
      last_of_run <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan;
      if (cand_take) begin
        best_found <= 1'b1;
      end
      if (cmd.scan) begin
        scan_idx <= scan_idx + SLOT_W'(1);
      end
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      if (cmd.arm) begin
        if (arm_ok) begin
          armed[SLOT_W'(lat_sid)] <= 1'b1;
        end
        rsp_valid   <= 1'b1;
        event_res   <= dts_pkg::EV_ACK;
        fired_slot  <= '0;
        fired_kind  <= dts_pkg::KIND_PERIODIC;
        last_of_run <= 1'b1;
      end

      if (cmd.tick) begin
        now_count  <= now_count + TW'(1);
        done       <= '0;
        scan_idx   <= '0;
        best_found <= 1'b0;
        pend_valid <= 1'b0;
      end

      if (cmd.take_best) begin
        done[best_idx] <= 1'b1;
        if (best_kind != dts_pkg::KIND_PERIODIC) begin
          armed[best_idx] <= 1'b0;
        end
        // The previous winner is known not to be the last word of the run.
        if (pend_valid) begin
          rsp_valid   <= 1'b1;
          event_res   <= pend_ev;
          fired_slot  <= pend_slot;
          fired_kind  <= pend_kind;
          last_of_run <= 1'b0;
        end
        pend_valid <= 1'b1;
        best_found <= 1'b0;
        scan_idx   <= '0;
      end

      if (cmd.finish) begin
        rsp_valid   <= 1'b1;
        last_of_run <= 1'b1;
        pend_valid  <= 1'b0;
        if (pend_valid) begin
          event_res  <= pend_ev;
          fired_slot <= pend_slot;
          fired_kind <= pend_kind;
        end else begin
          event_res  <= dts_pkg::EV_ACK;
          fired_slot <= '0;
          fired_kind <= dts_pkg::KIND_PERIODIC;
        end
      end
    end
  end

  assign stat.scan_last  = (scan_idx == SLOT_W'(SLOT_COUNT - 1));
  assign stat.best_found = best_found;
  assign stat.out_free   = out_free;

endmodule

`default_nettype wire

// File: rtl/dts_ctrl.sv
// Controller: sequences arm writes, tick scan passes and result hand-off.
`default_nettype none

module dts_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  input  wire logic [dts_pkg::OP_W-1:0] req_op,
  output      logic                     req_ready,
  input  wire dts_pkg::stat_t           stat,
  output      dts_pkg::cmd_t            cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARM,
    S_TICK,
    S_SCAN,
    S_WAIT,
    S_DECIDE
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.latch = req_valid;
      end
      S_ARM: begin
        cmd.arm = stat.out_free;
      end
      S_TICK: begin
        cmd.tick = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_DECIDE: begin
        cmd.take_best = stat.out_free && stat.best_found;
        cmd.finish    = stat.out_free && !stat.best_found;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (req_op == dts_pkg::OP_TICK) ? S_TICK : S_ARM;
          end
        end
        S_ARM: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        S_TICK: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_WAIT;
          end
        end
        // The last read of a pass is compared here.
        S_WAIT: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (stat.out_free) begin
            state <= stat.best_found ? S_SCAN : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/deadline_timer_scheduler.sv
// Timer slot table that reports due slots in earliest-deadline order on each tick.
// Arm: after accept the controller enters its arm state, where the result word is registered
// once the output is free; it then returns to idle to accept the next word. Tick: each scan
// pass reads one slot per cycle from the slot RAM; with k due slots a tick runs k + 1 passes.
// Synchronous active-high reset clears the time counter, all armed bits and the controller;
// the table is usable as soon as reset is released.
`default_nettype none

module deadline_timer_scheduler #(
  parameter int SLOT_COUNT = dts_pkg::SLOT_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  dts_in_if.sink    req,
  dts_out_if.source rsp
);

  dts_pkg::cmd_t  cmd;
  dts_pkg::stat_t stat;
  logic           req_ready;

  assign req.ready = req_ready;

  dts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_op   (req.operation),
    .req_ready(req_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dts_datapath #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .slot_id    (req.slot_id),
    .delay_ticks(req.delay_ticks),
    .task_kind  (req.task_kind),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .event_res  (rsp.event_res),
    .fired_slot (rsp.fired_slot),
    .fired_kind (rsp.fired_kind),
    .last_of_run(rsp.last_of_run)
  );

endmodule

`default_nettype wire

// File: rtl/dts_checker.sv
// Port-level assertions for the scheduler, bound to the top level.
`default_nettype none

module dts_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [dts_pkg::EV_W-1:0]      event_res,
  input wire logic [dts_pkg::SLOT_ID_W-1:0] fired_slot,
  input wire logic [dts_pkg::KIND_W-1:0]    fired_kind,
  input wire logic                          last_of_run
);

  // A stalled result word holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res) && $stable(fired_slot) &&
      $stable(fired_kind) && $stable(last_of_run))
    else $error("result word changed while stalled");

  // One word at a time: the block is busy right after accepting a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input accepted on consecutive cycles");

  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && event_res == dts_pkg::EV_ACK |->
      last_of_run && fired_slot == '0 && fired_kind == dts_pkg::KIND_PERIODIC)
    else $error("acknowledge word is not a closing empty word");

  a_drop_is_network: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && event_res == dts_pkg::EV_DROP |-> fired_kind == dts_pkg::KIND_NETWORK)
    else $error("dropped slot is not a network slot");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> event_res == dts_pkg::EV_ACK || event_res == dts_pkg::EV_FIRE ||
      event_res == dts_pkg::EV_DROP)
    else $error("undefined event code");

endmodule

bind deadline_timer_scheduler dts_checker u_dts_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .event_res  (rsp.event_res),
  .fired_slot (rsp.fired_slot),
  .fired_kind (rsp.fired_kind),
  .last_of_run(rsp.last_of_run)
);

`default_nettype wire
